[rtl/fragment_reassembly_bitmap_tracker_assert.svh]
// Assertion macros used by the checker file of the fragment tracker.
`ifndef FRAGMENT_REASSEMBLY_BITMAP_TRACKER_ASSERT_SVH
`define FRAGMENT_REASSEMBLY_BITMAP_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define FRBT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frbt assertion failed");

// Next-cycle implication, disabled while reset is high.
`define FRBT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frbt assertion failed");

`endif

[rtl/frbt_pkg.sv]
// Shared types and constants of the fragment reassembly bitmap tracker.
package frbt_pkg;

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_FRAGMENT = 2'd0,
    CMD_SYNC     = 2'd1,
    CMD_TICK     = 2'd2
  } cmd_t;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_STORED    = 3'd0,
    STAT_IGNORED   = 3'd1,
    STAT_FRAG_ERR  = 3'd2,
    STAT_NOT_REQ   = 3'd3,
    STAT_UNKNOWN   = 3'd4,
    STAT_NEED_MORE = 3'd5,
    STAT_ACK       = 3'd6,
    STAT_EXPIRED   = 3'd7
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_READ,
    S_RMW,
    S_RESP,
    S_STREAM
  } state_t;

  // One result word.
  typedef struct packed {
    status_t     status;
    logic [4:0]  byte_index;
    logic [7:0]  map_byte;
    logic [5:0]  map_bytes;
    logic        last;
  } result_t;

  // Result word handed to the output register.
  typedef struct packed {
    logic    valid;
    result_t res;
  } res_push_t;

  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd1000;

endpackage

[rtl/fragment_reassembly_bitmap_tracker.sv]
// Top level of the fragment reassembly bitmap tracker with its output register.
// Tracks one transfer's missing-fragment map in a single-port-write, one-read
// memory of (MAX_FRAGMENTS+7)/8 bytes. A fragment for an open context passes through
// read, modify-write and response, the read issued as the item is accepted; a fragment
// that opens a context first fills every map byte and then reads. A sync that
// finds missing fragments streams one map byte per cycle while the output register
// can take it, paced by the memory read port; other syncs, errors and expiring
// ticks go straight to the response, and a tick that causes no result leaves it idle. Results
// sit in an output register, so a new word is taken while the previous result waits
// downstream. Map bytes need no clearing after reset; opening a context writes them.
module fragment_reassembly_bitmap_tracker #(
  parameter int MAX_FRAGMENTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [15:0] frag_total,
  input  logic [15:0] sequence_req,
  input  logic        label_requested,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [4:0]  byte_index,
  output logic [7:0]  map_byte,
  output logic [5:0]  map_bytes,
  output logic        last
);

  import frbt_pkg::*;

  localparam int MAP_BYTES = (MAX_FRAGMENTS + 7) / 8;
  localparam int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

  logic          slot_free;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_q;
  res_push_t     push;
  result_t       out_res;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || out_ready;

  frbt_ctrl #(
    .MAX_FRAGMENTS(MAX_FRAGMENTS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .frag_total     (frag_total),
    .sequence_req   (sequence_req),
    .label_requested(label_requested),
    .slot_free      (slot_free),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_q          (ram_q),
    .push           (push)
  );

  frbt_map_ram #(
    .DEPTH(MAP_BYTES),
    .AW   (AW)
  ) u_map_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .q    (ram_q)
  );

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      out_res <= push.res;
    end
  end

  assign status     = out_res.status;
  assign byte_index = out_res.byte_index;
  assign map_byte   = out_res.map_byte;
  assign map_bytes  = out_res.map_bytes;
  assign last       = out_res.last;

endmodule

[rtl/frbt_map_ram.sv]
// Missing-map memory: one write port, one read port with registered data.
module frbt_map_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    q
);

  logic [7:0] mem [DEPTH];

  // Write one byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one byte, hold data when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      q <= mem[raddr];
    end
  end

endmodule

[rtl/frbt_ctrl.sv]
// Context registers and sequencer that drive the missing-map memory.
module frbt_ctrl #(
  parameter  int MAX_FRAGMENTS = 256,
  localparam int MAP_BYTES     = (MAX_FRAGMENTS + 7) / 8,
  localparam int AW            = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          command,
  input  logic [15:0]         frag_total,
  input  logic [15:0]         sequence_req,
  input  logic                label_requested,
  input  logic                slot_free,
  output logic                ram_re,
  output logic [AW-1:0]       ram_raddr,
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output logic [7:0]          ram_wdata,
  input  logic [7:0]          ram_q,
  output frbt_pkg::res_push_t push
);

  import frbt_pkg::*;

  localparam int CW = $clog2(MAX_FRAGMENTS + 1);
  localparam int NW = $clog2(MAP_BYTES + 1);

  state_t         state, state_next;
  logic           ctx_open, ctx_open_next;
  logic           done, done_next;
  logic [CW-1:0]  frag_count, frag_count_next;
  logic [CW-1:0]  missing, missing_next;
  logic [15:0]    idle_ticks, idle_ticks_next;
  logic [15:0]    idle_timeout;
  logic [AW-1:0]  idx, idx_next;
  logic [AW+2:0]  seq, seq_next;
  result_t        resp, resp_next;

  logic           accept;
  logic [CW:0]    count_plus7;
  logic [NW-1:0]  n_bytes;
  logic [NW-1:0]  n_last;
  logic           idx_last;
  logic           bad_ann;
  logic           seq_ok;
  logic           frag_open;
  logic           frag_rmw;
  logic           sync_stream;
  logic           tick_live;
  logic           tick_expire;
  logic [15:0]    idle_inc;
  logic [2:0]     bit_sel;
  logic [7:0]     fill_data;

  // Decode the current item against the context
  assign accept      = in_valid & in_ready;
  assign count_plus7 = {1'b0, frag_count} + (CW+1)'(7);
  assign n_bytes     = NW'(count_plus7 >> 3);
  assign n_last      = n_bytes - NW'(1);
  assign idx_last    = (NW'(idx) == n_last);
  assign bad_ann     = (frag_total == 16'd0) || (sequence_req >= frag_total) ||
                       (frag_total > 16'(MAX_FRAGMENTS));
  assign seq_ok      = sequence_req < 16'(frag_count);
  assign frag_open   = !bad_ann && !ctx_open && label_requested;
  assign frag_rmw    = !bad_ann && ctx_open && !done && seq_ok;
  assign sync_stream = ctx_open && (missing != '0);
  assign tick_live   = ctx_open && !done;
  assign idle_inc    = (idle_ticks != 16'hffff) ? idle_ticks + 16'd1 : idle_ticks;
  assign tick_expire = tick_live && (idle_inc >= idle_timeout);
  assign bit_sel     = seq[2:0];

  // Last map byte keeps only the bits of announced fragments
  assign fill_data = (idx_last && (frag_count[2:0] != 3'd0)) ?
                     (8'h7f >> (3'd7 - frag_count[2:0])) : 8'hff;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (command)
            CMD_FRAGMENT: begin
              if (frag_open) begin
                state_next = S_FILL;
              end else if (frag_rmw) begin
                state_next = S_RMW;
              end else begin
                state_next = S_RESP;
              end
            end
            CMD_SYNC: state_next = sync_stream ? S_STREAM : S_RESP;
            CMD_TICK: state_next = tick_expire ? S_RESP : S_IDLE;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_FILL:   if (idx_last) state_next = S_READ;
      S_READ:   state_next = S_RMW;
      S_RMW:    state_next = S_RESP;
      S_RESP:   if (slot_free) state_next = S_IDLE;
      S_STREAM: if (slot_free && idx_last) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Memory accesses, handshake and result words
  always_comb begin
    in_ready  = (state == S_IDLE);
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    push      = '0;
    case (state)
      S_IDLE: begin
        if (accept && (command == CMD_FRAGMENT) && frag_rmw) begin
          ram_re    = 1'b1;
          ram_raddr = sequence_req[AW+2:3];
        end
        if (accept && (command == CMD_SYNC) && sync_stream) begin
          ram_re = 1'b1;
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = fill_data;
      end
      S_READ: begin
        ram_re    = 1'b1;
        ram_raddr = seq[AW+2:3];
      end
      S_RMW: begin
        ram_we    = 1'b1;
        ram_waddr = seq[AW+2:3];
        ram_wdata = ram_q & ~(8'h01 << bit_sel);
      end
      S_RESP: begin
        push.valid = slot_free;
        push.res   = resp;
      end
      S_STREAM: begin
        push.valid          = slot_free;
        push.res.status     = STAT_NEED_MORE;
        push.res.byte_index = 5'(idx);
        push.res.map_byte   = ram_q;
        push.res.map_bytes  = 6'(n_bytes);
        push.res.last       = idx_last;
        // fetch the next byte while this one goes out
        if (slot_free && !idx_last) begin
          ram_re    = 1'b1;
          ram_raddr = idx + AW'(1);
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Context updates
  always_comb begin
    ctx_open_next   = ctx_open;
    done_next       = done;
    frag_count_next = frag_count;
    missing_next    = missing;
    idle_ticks_next = idle_ticks;
    idx_next        = idx;
    seq_next        = seq;
    resp_next       = resp;
    case (state)
      S_IDLE: begin
        if (accept) begin
          seq_next       = sequence_req[AW+2:0];
          resp_next      = '0;
          resp_next.last = 1'b1;
          case (command)
            CMD_FRAGMENT: begin
              if (bad_ann) begin
                resp_next.status = STAT_FRAG_ERR;
              end else if (!ctx_open) begin
                if (!label_requested) begin
                  resp_next.status = STAT_NOT_REQ;
                end else begin
                  // open a context with every fragment missing
                  ctx_open_next   = 1'b1;
                  done_next       = 1'b0;
                  idle_ticks_next = '0;
                  frag_count_next = frag_total[CW-1:0];
                  missing_next    = frag_total[CW-1:0];
                  idx_next        = '0;
                  resp_next.status = STAT_STORED;
                end
              end else if (done) begin
                resp_next.status = STAT_IGNORED;
              end else if (!seq_ok) begin
                resp_next.status = STAT_FRAG_ERR;
              end else begin
                idle_ticks_next  = '0;
                resp_next.status = STAT_STORED;
              end
            end
            CMD_SYNC: begin
              if (!ctx_open) begin
                resp_next.status = STAT_UNKNOWN;
              end else begin
                idle_ticks_next = '0;
                idx_next        = '0;
                if (!sync_stream) begin
                  done_next           = 1'b1;
                  resp_next.status    = STAT_ACK;
                  resp_next.map_bytes = 6'(n_bytes);
                end
              end
            end
            CMD_TICK: begin
              if (tick_live) begin
                if (tick_expire) begin
                  ctx_open_next    = 1'b0;
                  idle_ticks_next  = '0;
                  resp_next.status = STAT_EXPIRED;
                end else begin
                  idle_ticks_next = idle_inc;
                end
              end
            end
            default: begin
              seq_next = seq;
            end
          endcase
        end
      end
      S_FILL: begin
        idx_next = idx + AW'(1);
      end
      S_RMW: begin
        // count the fragment only if its bit was still set
        if (ram_q[bit_sel]) begin
          missing_next = missing - CW'(1);
        end
      end
      S_STREAM: begin
        if (slot_free && !idx_last) begin
          idx_next = idx + AW'(1);
        end
      end
      default: begin
        idx_next = idx;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ctx_open     <= 1'b0;
      done         <= 1'b0;
      frag_count   <= '0;
      missing      <= '0;
      idle_ticks   <= '0;
      idle_timeout <= IDLE_TIMEOUT_RST;
    end else begin
      state      <= state_next;
      ctx_open   <= ctx_open_next;
      done       <= done_next;
      frag_count <= frag_count_next;
      missing    <= missing_next;
      idle_ticks <= idle_ticks_next;
      if (cfg_valid) begin
        idle_timeout <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx  <= idx_next;
    seq  <= seq_next;
    resp <= resp_next;
  end

endmodule

[rtl/frbt_checker.sv]
// Port-level checks of the fragment tracker and their bind to the top level.
`include "fragment_reassembly_bitmap_tracker_assert.svh"

module frbt_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [4:0] byte_index,
  input logic [7:0] map_byte,
  input logic [5:0] map_bytes,
  input logic       last
);

  import frbt_pkg::*;

  // A stalled result word holds
  `FRBT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status) && $stable(byte_index) && $stable(map_byte) && $stable(last))

  // Only map runs and acks carry a map length; single results end their run
  `FRBT_ASSERT_NOW(a_single_fields, clk, rst, out_valid && (status != STAT_NEED_MORE) && (status != STAT_ACK), (map_bytes == 6'd0) && (byte_index == 5'd0) && (map_byte == 8'd0) && last)

  // A map run continues with the next byte and nothing else
  `FRBT_ASSERT_NEXT(a_run_order, clk, rst, out_valid && out_ready && (status == STAT_NEED_MORE) && !last, !out_valid || ((status == STAT_NEED_MORE) && (byte_index == 5'($past(byte_index) + 5'd1))))

endmodule

bind fragment_reassembly_bitmap_tracker frbt_checker u_frbt_checker (.*);

[verif/fragment_reassembly_bitmap_tracker_tb.sv]
// Self-checking testbench for the fragment reassembly bitmap tracker.
module fragment_reassembly_bitmap_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import frbt_pkg::*;

  localparam int MAX_FRAGS    = 256;
  localparam int MAP_LEN      = (MAX_FRAGS + 7) / 8;
  localparam int SETTLE       = 48;     // longest internal run: map fill or full stream
  localparam int STALL_LIMIT  = 4000;   // cycles without any word moving
  localparam int RANDOM_WORDS = 140;
  localparam int LONG_HOLD    = 400;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  command;
  logic [15:0] frag_total;
  logic [15:0] sequence_req;
  logic        label_requested;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [4:0]  byte_index;
  logic [7:0]  map_byte;
  logic [5:0]  map_bytes;
  logic        last;

  fragment_reassembly_bitmap_tracker #(
    .MAX_FRAGMENTS(MAX_FRAGS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .frag_total(frag_total),
    .sequence_req(sequence_req),
    .label_requested(label_requested),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .byte_index(byte_index),
    .map_byte(map_byte),
    .map_bytes(map_bytes),
    .last(last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the transfer tracker
  logic [7:0]  map_bits [MAP_LEN];
  logic [8:0]  frag_count;
  bit          ctx_open;
  bit          xfer_done;
  logic [15:0] idle_count;
  logic [15:0] idle_limit;
  result_t     pending_results [$];

  int mismatch_count = 0;
  int burst_left     = 0;
  int hold_request   = 0;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  function automatic void push_result(input status_t st, input int idx, input int mbyte,
                                      input int nbytes, input bit is_last);
    result_t r;
    r.status     = st;
    r.byte_index = 5'(idx);
    r.map_byte   = 8'(mbyte);
    r.map_bytes  = 6'(nbytes);
    r.last       = is_last;
    pending_results.push_back(r);
  endfunction

  function automatic int map_len();
    return (int'(frag_count) + 7) / 8;
  endfunction

  function automatic bit map_has_holes();
    for (int i = 0; i < map_len(); i++) begin
      if (map_bits[i] != 8'h00) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the shadow tracker by one input word and queue the words it causes
  function automatic int predict_transfer(input logic [1:0] cmd, input logic [15:0] total,
                                          input logic [15:0] seq, input logic req);
    int n;
    int rem;
    int before_count;
    before_count = pending_results.size();
    case (cmd)
      CMD_FRAGMENT: begin
        if (total == 16'd0 || seq >= total || int'(total) > MAX_FRAGS) begin
          push_result(STAT_FRAG_ERR, 0, 0, 0, 1'b1);
        end else if (!ctx_open && !req) begin
          push_result(STAT_NOT_REQ, 0, 0, 0, 1'b1);
        end else begin
          // open a context: every announced fragment starts out missing
          if (!ctx_open) begin
            frag_count = 9'(total);
            n = map_len();
            for (int i = 0; i < n; i++) map_bits[i] = 8'hff;
            rem = int'(total) % 8;
            if (rem != 0) map_bits[n - 1] = 8'hff >> (8 - rem);
            ctx_open   = 1'b1;
            xfer_done  = 1'b0;
            idle_count = 16'd0;
          end
          if (xfer_done) begin
            push_result(STAT_IGNORED, 0, 0, 0, 1'b1);
          end else if (int'(seq) >= int'(frag_count)) begin
            push_result(STAT_FRAG_ERR, 0, 0, 0, 1'b1);
          end else begin
            idle_count = 16'd0;
            map_bits[seq[7:3]][seq[2:0]] = 1'b0;
            push_result(STAT_STORED, 0, 0, 0, 1'b1);
          end
        end
      end
      CMD_SYNC: begin
        if (!ctx_open) begin
          push_result(STAT_UNKNOWN, 0, 0, 0, 1'b1);
        end else begin
          idle_count = 16'd0;
          n = map_len();
          if (map_has_holes()) begin
            for (int i = 0; i < n; i++)
              push_result(STAT_NEED_MORE, i, int'(map_bits[i]), n, i == n - 1);
          end else begin
            xfer_done = 1'b1;
            push_result(STAT_ACK, 0, 0, n, 1'b1);
          end
        end
      end
      CMD_TICK: begin
        // age an open, incomplete context
        if (ctx_open && !xfer_done) begin
          if (idle_count != 16'hffff) idle_count++;
          if (idle_count >= idle_limit) begin
            ctx_open   = 1'b0;
            idle_count = 16'd0;
            push_result(STAT_EXPIRED, 0, 0, 0, 1'b1);
          end
        end
      end
      default: ;
    endcase
    return pending_results.size() - before_count;
  endfunction

  // Offer one input word in bursts with random gaps; entered and left at a falling edge
  task automatic send_word(input logic [1:0] cmd, input logic [15:0] total,
                           input logic [15:0] seq, input logic req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    command         <= cmd;
    frag_total      <= total;
    sequence_req    <= seq;
    label_requested <= req;
    do @(posedge clk); while (in_ready !== 1'b1);
    void'(predict_transfer(cmd, total, seq, req));
    @(negedge clk);
  endtask

  // Hold the input until every expected word is out, then let the block settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    wait_drained();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    idle_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // No-context cases, malformed announcements, opening and a short need-more run
  task automatic test_directed();
    send_word(CMD_SYNC, 16'd0, 16'd0, 1'b0);
    send_word(CMD_TICK, 16'd0, 16'd0, 1'b0);
    send_word(CMD_RESERVED, 16'hffff, 16'hffff, 1'b1);
    send_word(CMD_FRAGMENT, 16'd0, 16'd0, 1'b1);
    send_word(CMD_FRAGMENT, 16'd5, 16'd5, 1'b1);
    send_word(CMD_FRAGMENT, 16'(MAX_FRAGS + 1), 16'd0, 1'b1);
    send_word(CMD_FRAGMENT, 16'hffff, 16'hffff, 1'b1);
    send_word(CMD_FRAGMENT, 16'd10, 16'd3, 1'b0);
    send_word(CMD_FRAGMENT, 16'd9, 16'd8, 1'b1);
    // sequence past the stored total, though within the announced one
    send_word(CMD_FRAGMENT, 16'd12, 16'd11, 1'b1);
    send_word(CMD_FRAGMENT, 16'd9, 16'd0, 1'b0);
    send_word(CMD_SYNC, 16'd0, 16'd0, 1'b0);
    send_word(CMD_TICK, 16'd0, 16'd0, 1'b0);
    send_word(CMD_FRAGMENT, 16'(MAX_FRAGS), 16'd4, 1'b1);
  endtask

  task automatic test_expiry();
    write_timeout(16'd1);
    send_word(CMD_TICK, 16'd0, 16'd0, 1'b0);
    send_word(CMD_SYNC, 16'd0, 16'd0, 1'b0);
    // zero timeout expires on the first tick
    write_timeout(16'd0);
    send_word(CMD_FRAGMENT, 16'd8, 16'd7, 1'b1);
    send_word(CMD_TICK, 16'd0, 16'd0, 1'b0);
    // fragments and syncs restart the idle count
    write_timeout(16'd3);
    send_word(CMD_FRAGMENT, 16'd20, 16'd5, 1'b1);
    repeat (2) send_word(CMD_TICK, 16'd0, 16'd0, 1'b0);
    send_word(CMD_FRAGMENT, 16'd20, 16'd6, 1'b1);
    repeat (2) send_word(CMD_TICK, 16'd0, 16'd0, 1'b0);
    send_word(CMD_SYNC, 16'd0, 16'd0, 1'b0);
    repeat (4) send_word(CMD_TICK, 16'd0, 16'd0, 1'b0);
  endtask

  // Largest map; long receiver hold-off while syncs keep arriving
  task automatic test_full_map();
    write_timeout(16'hffff);
    send_word(CMD_FRAGMENT, 16'(MAX_FRAGS), 16'(MAX_FRAGS - 1), 1'b1);
    send_word(CMD_FRAGMENT, 16'(MAX_FRAGS), 16'd0, 1'b1);
    hold_request = LONG_HOLD;
    repeat (6) begin
      send_word(CMD_SYNC, 16'd0, 16'd0, 1'b0);
      send_word(CMD_TICK, 16'd0, 16'd0, 1'b0);
    end
    write_timeout(16'd2);
    repeat (2) send_word(CMD_TICK, 16'd0, 16'd0, 1'b0);
  endtask

  // Transfers with random content, each left to age out so the next can open
  task automatic test_random();
    int counted;
    int total;
    int pick;
    int lo;
    int hi;
    logic [15:0] seq;
    counted = 0;
    while (counted < RANDOM_WORDS) begin
      write_timeout(16'($urandom_range(1, 12)));
      repeat ($urandom_range(2, 4)) begin
        total = ($urandom_range(0, 9) == 0) ? $urandom_range(200, MAX_FRAGS)
                                            : $urandom_range(1, 40);
        repeat ($urandom_range(3, 14)) begin
          pick = $urandom_range(0, 99);
          seq  = 16'($urandom_range(0, total - 1));
          if (pick < 55) begin
            send_word(CMD_FRAGMENT, 16'(total), seq, $urandom_range(0, 9) != 0);
          end else if (pick < 65) begin
            // never complete here: a completed context stays open for good
            if (!ctx_open || map_has_holes())
              send_word(CMD_SYNC, 16'($urandom), 16'($urandom), 1'($urandom));
            else
              send_word(CMD_TICK, 16'($urandom), 16'($urandom), 1'($urandom));
          end else if (pick < 80) begin
            send_word(CMD_TICK, 16'($urandom), 16'($urandom), 1'($urandom));
          end else if (pick < 90) begin
            case ($urandom_range(0, 3))
              0: send_word(CMD_FRAGMENT, 16'd0, 16'($urandom), 1'b1);
              1: send_word(CMD_FRAGMENT, 16'(total), 16'(total + $urandom_range(0, 300)), 1'b1);
              2: send_word(CMD_FRAGMENT, 16'($urandom_range(MAX_FRAGS + 1, 16'hffff)),
                           16'($urandom), 1'($urandom));
              default: begin
                if (ctx_open && int'(frag_count) < MAX_FRAGS) begin
                  lo = int'(frag_count);
                  hi = $urandom_range(lo + 1, MAX_FRAGS);
                  send_word(CMD_FRAGMENT, 16'(hi), 16'($urandom_range(lo, hi - 1)), 1'b1);
                end else begin
                  send_word(CMD_FRAGMENT, 16'($urandom), 16'($urandom), 1'($urandom));
                end
              end
            endcase
          end else if (pick < 95) begin
            send_word(CMD_RESERVED, 16'($urandom), 16'($urandom), 1'($urandom));
          end else begin
            send_word(CMD_FRAGMENT, 16'($urandom), 16'($urandom), 1'($urandom));
          end
          counted++;
        end
        while (ctx_open && !xfer_done) begin
          send_word(CMD_TICK, 16'($urandom), 16'($urandom), 1'($urandom));
          counted++;
        end
      end
    end
  endtask

  // Deliver every fragment, then acknowledge; afterwards fragments are ignored
  task automatic test_completion();
    int total;
    int start;
    int idx;
    int pick;
    write_timeout(16'hffff);
    total = $urandom_range(17, 40);
    send_word(CMD_FRAGMENT, 16'(total), 16'($urandom_range(0, total - 1)), 1'b1);
    while (map_has_holes()) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        start = $urandom_range(0, total - 1);
        idx = start;
        for (int k = 0; k < total; k++) begin
          idx = (start + k) % total;
          if (map_bits[idx / 8][idx % 8]) break;
        end
        send_word(CMD_FRAGMENT, 16'(total), 16'(idx), 1'b1);
      end else if (pick == 7) begin
        send_word(CMD_SYNC, 16'd0, 16'd0, 1'b0);
      end else begin
        send_word(CMD_FRAGMENT, 16'(total), 16'($urandom_range(0, total - 1)), 1'b0);
      end
    end
    send_word(CMD_SYNC, 16'd0, 16'd0, 1'b0);
    send_word(CMD_FRAGMENT, 16'(total), 16'd0, 1'b1);
    send_word(CMD_FRAGMENT, 16'd0, 16'd0, 1'b1);
    send_word(CMD_TICK, 16'd0, 16'd0, 1'b0);
    send_word(CMD_SYNC, 16'd0, 16'd0, 1'b0);
    send_word(CMD_RESERVED, 16'd0, 16'd0, 1'b0);
  endtask

  // Receiver: stall modes of random length, plus a long hold-off on request
  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= $urandom_range(0, 1) == 1;
          default: out_ready <= $urandom_range(0, 3) == 0;
        endcase
      end
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("word with nothing expected, status %0d", status));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", status, want.status));
        if (byte_index !== want.byte_index)
          report_mismatch($sformatf("byte_index got %0d want %0d", byte_index, want.byte_index));
        if (map_byte !== want.map_byte)
          report_mismatch($sformatf("map_byte got %0h want %0h", map_byte, want.map_byte));
        if (map_bytes !== want.map_bytes)
          report_mismatch($sformatf("map_bytes got %0d want %0d", map_bytes, want.map_bytes));
        if (last !== want.last)
          report_mismatch($sformatf("last got %0d want %0d", last, want.last));
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL fragment_reassembly_bitmap_tracker");
    $finish;
  end

  initial begin
    rst             = 1'b1;
    cfg_valid       = 1'b0;
    cfg_data        = 16'd0;
    in_valid        = 1'b0;
    command         = CMD_FRAGMENT;
    frag_total      = 16'd0;
    sequence_req    = 16'd0;
    label_requested = 1'b0;
    frag_count      = 9'd0;
    ctx_open        = 1'b0;
    xfer_done       = 1'b0;
    idle_count      = 16'd0;
    idle_limit      = IDLE_TIMEOUT_RST;
    foreach (map_bits[i]) map_bits[i] = 8'h00;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_expiry();
    test_full_map();
    test_random();
    test_completion();

    wait_drained();
    if (mismatch_count == 0)
      $display("PASS fragment_reassembly_bitmap_tracker");
    else
      $display("FAIL fragment_reassembly_bitmap_tracker");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/frbt_pkg.sv
rtl/frbt_map_ram.sv
rtl/frbt_ctrl.sv
rtl/fragment_reassembly_bitmap_tracker.sv
rtl/frbt_checker.sv
verif/fragment_reassembly_bitmap_tracker_tb.sv
